// ----- rtl/tga_stream_decoder_macros.svh -----
// Assertion macros for the TGA stream decoder.
// Both expect i_clk and i_rst_n in the enclosing module.
`ifndef TGA_STREAM_DECODER_MACROS_SVH
`define TGA_STREAM_DECODER_MACROS_SVH

`ifndef SYNTHESIS
`define TGA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tga assertion failed");
`define TGA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) ante |=> cons) \
        else $error("tga assertion failed");
`else
`define TGA_ASSERT(lbl, prop)
`define TGA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- rtl/tga_pkg.sv -----
package tga_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER_OK,
        KIND_PIXEL,
        KIND_BAD_SIZE,
        KIND_BAD_TYPE
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic [2:0]  channel_count;
        logic [7:0]  chan_a;
        logic [7:0]  chan_b;
        logic [7:0]  chan_c;
        logic [7:0]  chan_d;
        logic [7:0]  repeat_count;
        logic        last_pixel;
    } t_result;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // header byte positions
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_TYPE      = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_LAST      = 5'd17;

    localparam logic [7:0] TYPE_RAW = 8'd2;
    localparam logic [7:0] TYPE_RLE = 8'd10;

    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [7:0] RUN_FLAG = 8'd128;
    localparam logic [7:0] RUN_BIAS = 8'd127;
    localparam logic [7:0] MAX_REP  = 8'd128;

endpackage

// ----- rtl/tga_parser.sv -----
`include "tga_stream_decoder_macros.svh"

module tga_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [7:0]       i_data_byte,
    input  logic             i_file_start,
    output logic             o_push,
    output tga_pkg::t_result o_result
);
    import tga_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PACKET,
        PH_PIXEL,
        PH_IDLE
    } t_phase;

    t_phase      r_phase, n_phase, cur_phase, data_phase;
    logic [4:0]  r_hdr_idx, n_hdr_idx, cur_idx;
    logic [7:0]  r_id_left, n_id_left;
    logic [7:0]  r_kind_code, n_kind_code;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [2:0]  r_bpp, n_bpp;
    logic [31:0] r_pix_left, n_pix_left;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_pkt_run, n_pkt_run;
    logic [1:0]  r_chan_idx, n_chan_idx;
    logic [31:0] r_asm, n_asm;

    logic [31:0] area;
    logic [31:0] asm_new;
    logic [31:0] pix_new;
    logic [7:0]  rep;
    logic [7:0]  pkt_new;
    logic        rle;

    assign area       = {16'd0, r_width} * {16'd0, r_height};
    assign rle        = (r_kind_code == TYPE_RLE);
    assign data_phase = rle ? PH_PACKET : PH_PIXEL;

    always_comb begin
        case (r_chan_idx)
            2'd0:    asm_new = r_asm | {24'd0, i_data_byte};
            2'd1:    asm_new = r_asm | {16'd0, i_data_byte, 8'd0};
            2'd2:    asm_new = r_asm | {8'd0, i_data_byte, 16'd0};
            default: asm_new = r_asm | {i_data_byte, 24'd0};
        endcase
    end

    always_comb begin
        pkt_new = r_pkt_left;
        if (rle && r_pkt_run) begin
            rep     = (r_pix_left < {24'd0, r_pkt_left}) ? r_pix_left[7:0] : r_pkt_left;
            pkt_new = 8'd0;
        end else begin
            rep = 8'd1;
            if (rle && r_pkt_left != 8'd0) begin
                pkt_new = r_pkt_left - 8'd1;
            end
        end
        pix_new = r_pix_left - {24'd0, rep};
    end

    always_comb begin
        cur_phase   = i_file_start ? PH_HEADER : r_phase;
        cur_idx     = i_file_start ? 5'd0 : r_hdr_idx;
        n_phase     = r_phase;
        n_hdr_idx   = r_hdr_idx;
        n_id_left   = r_id_left;
        n_kind_code = r_kind_code;
        n_width     = r_width;
        n_height    = r_height;
        n_bpp       = r_bpp;
        n_pix_left  = r_pix_left;
        n_pkt_left  = r_pkt_left;
        n_pkt_run   = r_pkt_run;
        n_chan_idx  = r_chan_idx;
        n_asm       = r_asm;
        o_push      = 1'b0;
        o_result    = '0;
        if (i_en) begin
            n_phase   = cur_phase;
            n_hdr_idx = cur_idx;
            case (cur_phase)
                PH_HEADER: begin
                    case (cur_idx)
                        HDR_ID_LEN:    n_id_left     = i_data_byte;
                        HDR_TYPE:      n_kind_code   = i_data_byte;
                        HDR_WIDTH_LO:  n_width[7:0]  = i_data_byte;
                        HDR_WIDTH_HI:  n_width[15:8] = i_data_byte;
                        HDR_HEIGHT_LO: n_height[7:0] = i_data_byte;
                        HDR_HEIGHT_HI: n_height[15:8] = i_data_byte;
                        HDR_DEPTH: begin
                            if (i_data_byte == DEPTH_8) begin
                                n_bpp = 3'd1;
                            end else if (i_data_byte == DEPTH_24) begin
                                n_bpp = 3'd3;
                            end else if (i_data_byte == DEPTH_32) begin
                                n_bpp = 3'd4;
                            end else begin
                                n_bpp = 3'd0;
                            end
                        end
                        default: ;
                    endcase
                    if (cur_idx < HDR_LAST) begin
                        n_hdr_idx = cur_idx + 5'd1;
                    end else begin
                        n_hdr_idx              = 5'd0;
                        o_push                 = 1'b1;
                        o_result.image_width   = r_width;
                        o_result.image_height  = r_height;
                        o_result.channel_count = r_bpp;
                        if (r_width == 16'd0 || r_height == 16'd0 || r_bpp == 3'd0) begin
                            o_result.kind = KIND_BAD_SIZE;
                            n_phase       = PH_IDLE;
                        end else if (r_kind_code != TYPE_RAW && r_kind_code != TYPE_RLE) begin
                            o_result.kind = KIND_BAD_TYPE;
                            n_phase       = PH_IDLE;
                        end else begin
                            o_result.kind = KIND_HEADER_OK;
                            n_pix_left    = area;
                            n_pkt_left    = 8'd0;
                            n_pkt_run     = 1'b0;
                            n_chan_idx    = 2'd0;
                            n_asm         = 32'd0;
                            n_phase       = (r_id_left != 8'd0) ? PH_SKIP : data_phase;
                        end
                    end
                end
                PH_SKIP: begin
                    n_id_left = r_id_left - ((r_id_left != 8'd0) ? 8'd1 : 8'd0);
                    if (n_id_left == 8'd0) begin
                        n_phase = data_phase;
                    end
                end
                PH_PACKET: begin
                    if (i_data_byte < RUN_FLAG) begin
                        n_pkt_run  = 1'b0;
                        n_pkt_left = i_data_byte + 8'd1;
                    end else begin
                        n_pkt_run  = 1'b1;
                        n_pkt_left = i_data_byte - RUN_BIAS;
                    end
                    n_chan_idx = 2'd0;
                    n_asm      = 32'd0;
                    n_phase    = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if ({1'b0, r_chan_idx} + 3'd1 < r_bpp) begin
                        n_asm      = asm_new;
                        n_chan_idx = r_chan_idx + 2'd1;
                    end else begin
                        n_chan_idx             = 2'd0;
                        n_asm                  = 32'd0;
                        n_pkt_left             = pkt_new;
                        n_pix_left             = pix_new;
                        o_push                 = 1'b1;
                        o_result.kind          = KIND_PIXEL;
                        o_result.image_width   = r_width;
                        o_result.image_height  = r_height;
                        o_result.channel_count = r_bpp;
                        o_result.repeat_count  = rep;
                        o_result.last_pixel    = (pix_new == 32'd0);
                        case (r_bpp)
                            3'd1: o_result.chan_a = asm_new[7:0];
                            3'd3: begin
                                o_result.chan_a = asm_new[23:16];
                                o_result.chan_b = asm_new[15:8];
                                o_result.chan_c = asm_new[7:0];
                            end
                            3'd4: begin
                                o_result.chan_a = asm_new[31:24];
                                o_result.chan_b = asm_new[23:16];
                                o_result.chan_c = asm_new[15:8];
                                o_result.chan_d = asm_new[7:0];
                            end
                            default: ;
                        endcase
                        if (pix_new == 32'd0) begin
                            n_phase = PH_IDLE;
                        end else if (rle && pkt_new == 8'd0) begin
                            n_phase = PH_PACKET;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_idx   <= 5'd0;
            r_id_left   <= 8'd0;
            r_kind_code <= 8'd0;
            r_width     <= 16'd0;
            r_height    <= 16'd0;
            r_bpp       <= 3'd0;
            r_pix_left  <= 32'd0;
            r_pkt_left  <= 8'd0;
            r_pkt_run   <= 1'b0;
            r_chan_idx  <= 2'd0;
            r_asm       <= 32'd0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_idx   <= n_hdr_idx;
            r_id_left   <= n_id_left;
            r_kind_code <= n_kind_code;
            r_width     <= n_width;
            r_height    <= n_height;
            r_bpp       <= n_bpp;
            r_pix_left  <= n_pix_left;
            r_pkt_left  <= n_pkt_left;
            r_pkt_run   <= n_pkt_run;
            r_chan_idx  <= n_chan_idx;
            r_asm       <= n_asm;
        end
    end

    `TGA_ASSERT(a_pixel_has_depth, (r_phase == PH_PIXEL) |->
        (r_bpp != 3'd0 && r_pix_left != 32'd0))
    `TGA_ASSERT(a_skip_nonzero, (r_phase == PH_SKIP) |-> (r_id_left != 8'd0))
    `TGA_ASSERT(a_rep_range, (o_push && o_result.kind == KIND_PIXEL) |->
        (o_result.repeat_count != 8'd0 && o_result.repeat_count <= MAX_REP))

endmodule

// ----- rtl/tga_queue.sv -----
`include "tga_stream_decoder_macros.svh"

module tga_queue #(
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tga_pkg::t_result i_data,
    input  logic             i_pop,
    output tga_pkg::t_result o_head,
    output tga_pkg::t_q_stat o_stat
);
    import tga_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr;
    logic [AW-1:0]   r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;

    assign o_head = r_mem[r_rd];
    assign o_stat = {(r_count == CW'(DEPTH)), (r_count == '0)};

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    `TGA_ASSERT(a_count_bound, r_count <= CW'(DEPTH))
    `TGA_ASSERT(a_no_pop_empty, (r_count == '0) |-> !i_pop)
    `TGA_ASSERT_NEXT(a_fills, (i_push && !i_pop && r_count == CW'(DEPTH - 1)), o_stat.full)

endmodule

// ----- rtl/tga_emitter.sv -----
`include "tga_stream_decoder_macros.svh"

module tga_emitter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tga_pkg::t_result i_head,
    input  tga_pkg::t_q_stat i_stat,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_image_width,
    output logic [15:0]      o_image_height,
    output logic [2:0]       o_channel_count,
    output logic [7:0]       o_chan_a,
    output logic [7:0]       o_chan_b,
    output logic [7:0]       o_chan_c,
    output logic [7:0]       o_chan_d,
    output logic [7:0]       o_repeat_count,
    output logic             o_last_pixel
);
    import tga_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_pop = !i_stat.empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_out_valid     = r_valid;
    assign o_kind          = r_res.kind;
    assign o_image_width   = r_res.image_width;
    assign o_image_height  = r_res.image_height;
    assign o_channel_count = r_res.channel_count;
    assign o_chan_a        = r_res.chan_a;
    assign o_chan_b        = r_res.chan_b;
    assign o_chan_c        = r_res.chan_c;
    assign o_chan_d        = r_res.chan_d;
    assign o_repeat_count  = r_res.repeat_count;
    assign o_last_pixel    = r_res.last_pixel;

    `TGA_ASSERT(a_last_is_pixel, (r_valid && r_res.last_pixel) |-> (r_res.kind == KIND_PIXEL))
    `TGA_ASSERT_NEXT(a_hold_valid, (r_valid && i_out_stall), r_valid)
    `TGA_ASSERT_NEXT(a_hold_payload, (r_valid && i_out_stall), $stable(r_res))

endmodule

// ----- rtl/tga_stream_decoder.sv -----
// Streaming TGA decoder: one file byte per transaction, one byte per clock
// while the result queue (QUEUE_DEPTH entries) has room; the input stalls only
// when the queue is full because the output side is stalled. The parser handles
// every byte as it is accepted, so a header result follows byte 17 of the header
// and a pixel result follows the last byte of each pixel (1, 3 or 4 bytes).
// Results leave the queue through an output register. Type 2 (raw) and type 10
// (run-length) images with 8, 24 or 32 bit depth are decoded; a run packet
// gives one result with its repeat count, a raw packet one result per pixel.
module tga_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [2:0]  o_channel_count,
    output logic [7:0]  o_chan_a,
    output logic [7:0]  o_chan_b,
    output logic [7:0]  o_chan_c,
    output logic [7:0]  o_chan_d,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_pixel
);
    import tga_pkg::*;

    logic    accept;
    logic    push;
    logic    pop;
    t_result push_data;
    t_result head;
    t_q_stat q_stat;

    assign o_in_stall = q_stat.full;
    assign accept     = i_in_valid && !q_stat.full;

    tga_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (accept),
        .i_data_byte  (i_data_byte),
        .i_file_start (i_file_start),
        .o_push       (push),
        .o_result     (push_data)
    );

    tga_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    tga_emitter u_emitter (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_stat          (q_stat),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_image_width   (o_image_width),
        .o_image_height  (o_image_height),
        .o_channel_count (o_channel_count),
        .o_chan_a        (o_chan_a),
        .o_chan_b        (o_chan_b),
        .o_chan_c        (o_chan_c),
        .o_chan_d        (o_chan_d),
        .o_repeat_count  (o_repeat_count),
        .o_last_pixel    (o_last_pixel)
    );

endmodule
